### rtl/ogq_pkg.sv
`default_nettype none

package ogq_pkg;

  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 256;

  localparam int DIM_W   = 9;
  localparam int COORD_W = 8;
  localparam int CELL_W  = 3;

  localparam logic [CELL_W-1:0] STATE_CLEAR    = 3'd0;
  localparam logic [CELL_W-1:0] STATE_OBSTACLE = 3'd1;
  localparam logic [CELL_W-1:0] STATE_LIMIT    = 3'd6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic CFG_HEIGHT = 1'b0;
  localparam logic CFG_WIDTH  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [CELL_W-1:0]  new_state;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] stored_state;
    logic              cell_is_clear;
    logic              near_obstacle;
    logic              out_of_range;
  } out_item_t;

  // one 3x3 neighbor as produced by the coordinate unit
  typedef struct packed {
    logic             ok;
    logic             center;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
  } nbr_t;

endpackage

`default_nettype wire

### rtl/occupancy_grid_obstacle_query.sv
// Channel   Handshake               Payload
// --------  ----------------------  ---------------------------------------
// input     start / busy            in_item  (operation, row, col, new_state)
// result    out_valid (one cycle)   out_item (state, clear, near, range)
// config    cfg_valid / cfg_ready   cfg_index, cfg_wdata (always ready)
//
// After reset the grid memory is cleared one cell per cycle, covering all
// 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells (65536 by default); busy stays high.
// A write or an out-of-range item returns its result in the cycle after start.
// A query walks the 3x3 window through the single memory port, one cell per
// cycle in ST_SCAN, then passes through ST_FLUSH; busy stays high in both.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none

module occupancy_grid_obstacle_query #(
  parameter int MAX_ROWS = ogq_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ogq_pkg::MAX_COLS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire ogq_pkg::in_item_t         in_item,
  output logic                           out_valid,
  output ogq_pkg::out_item_t             out_item,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic                      cfg_index,
  input  wire logic [ogq_pkg::DIM_W-1:0] cfg_wdata
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int CMP_W = 14;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } ogq_state_t;

  ogq_state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [ogq_pkg::DIM_W-1:0] rows_r, cols_r;
  logic [ogq_pkg::COORD_W-1:0] qrow_r, qrow_nxt, qcol_r, qcol_nxt;
  logic [1:0] di_r, di_nxt, dj_r, dj_nxt;
  logic rd_pend_r, rd_pend_nxt, rd_ctr_r, rd_ctr_nxt;
  logic near_r, near_nxt;
  logic [ogq_pkg::CELL_W-1:0] cst_r, cst_nxt;
  logic out_valid_r, out_valid_nxt;
  ogq_pkg::out_item_t out_r, out_nxt;

  ogq_pkg::nbr_t nbr;
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [ogq_pkg::CELL_W-1:0] ram_wdata, ram_rdata;
  logic in_grid;
  logic near_fold;
  logic [ogq_pkg::CELL_W-1:0] cst_fold;
  logic [RW+8:0] in_row_x, nb_row_x;
  logic [CW+8:0] in_col_x, nb_col_x;

  ogq_nbr_unit u_nbr (
    .ctr_row (qrow_r),
    .ctr_col (qcol_r),
    .di      (di_r),
    .dj      (dj_r),
    .rows    (rows_r),
    .cols    (cols_r),
    .nbr     (nbr)
  );

  ogq_ram #(
    .WIDTH (ogq_pkg::CELL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign in_row_x = (RW + 9)'(in_item.row);
  assign in_col_x = (CW + 9)'(in_item.col);
  assign nb_row_x = (RW + 9)'(nbr.row);
  assign nb_col_x = (CW + 9)'(nbr.col);

  assign in_grid = (ogq_pkg::DIM_W'(in_item.row) < rows_r) &&
                   (ogq_pkg::DIM_W'(in_item.col) < cols_r);

  // fold in the cell read issued last cycle
  assign near_fold = near_r | (rd_pend_r && (ram_rdata == ogq_pkg::STATE_OBSTACLE));
  assign cst_fold  = rd_ctr_r ? ram_rdata : cst_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    qrow_nxt      = qrow_r;
    qcol_nxt      = qcol_r;
    di_nxt        = di_r;
    dj_nxt        = dj_r;
    rd_pend_nxt   = 1'b0;
    rd_ctr_nxt    = 1'b0;
    near_nxt      = near_r;
    cst_nxt       = cst_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_addr      = {in_row_x[RW-1:0], in_col_x[CW-1:0]};
    ram_wdata     = in_item.new_state;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = ogq_pkg::STATE_CLEAR;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (!in_grid || (in_item.operation == ogq_pkg::OP_WRITE)) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.out_of_range = !in_grid;
            ram_we = in_grid && (in_item.new_state <= ogq_pkg::STATE_LIMIT);
          end else begin
            qrow_nxt  = in_item.row;
            qcol_nxt  = in_item.col;
            di_nxt    = 2'd0;
            dj_nxt    = 2'd0;
            near_nxt  = 1'b0;
            cst_nxt   = ogq_pkg::STATE_CLEAR;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ram_addr    = {nb_row_x[RW-1:0], nb_col_x[CW-1:0]};
        rd_pend_nxt = nbr.ok;
        rd_ctr_nxt  = nbr.center;
        near_nxt    = near_fold;
        cst_nxt     = cst_fold;
        if (dj_r == 2'd2) begin
          dj_nxt = 2'd0;
          di_nxt = di_r + 1'b1;
          if (di_r == 2'd2) begin
            state_nxt = ST_FLUSH;
          end
        end else begin
          dj_nxt = dj_r + 1'b1;
        end
      end
      ST_FLUSH: begin
        out_valid_nxt              = 1'b1;
        out_nxt.stored_state       = cst_fold;
        out_nxt.cell_is_clear      = (cst_fold == ogq_pkg::STATE_CLEAR);
        out_nxt.near_obstacle      = near_fold;
        out_nxt.out_of_range       = 1'b0;
        state_nxt                  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      rd_pend_r   <= 1'b0;
      rd_ctr_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rows_r      <= '0;
      cols_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_ctr_r    <= rd_ctr_nxt;
      out_valid_r <= out_valid_nxt;
      // hold dimensions already clamped to the grid size
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ogq_pkg::CFG_HEIGHT) begin
          rows_r <= (CMP_W'(cfg_wdata) > CMP_W'(MAX_ROWS)) ?
                    ogq_pkg::DIM_W'(MAX_ROWS) : cfg_wdata;
        end else if (cfg_index == ogq_pkg::CFG_WIDTH) begin
          cols_r <= (CMP_W'(cfg_wdata) > CMP_W'(MAX_COLS)) ?
                    ogq_pkg::DIM_W'(MAX_COLS) : cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    qrow_r   <= qrow_nxt;
    qcol_r   <= qcol_nxt;
    di_r     <= di_nxt;
    dj_r     <= dj_nxt;
    near_r   <= near_nxt;
    cst_r    <= cst_nxt;
    out_r    <= out_nxt;
  end

`ifndef SYNTHESIS
  a_out_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_FLUSH) || $past(start && !busy))
    else $error("result without an item in flight");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.out_of_range) |->
      (out_item.stored_state == '0) && !out_item.cell_is_clear && !out_item.near_obstacle)
    else $error("out-of-range result carries data");

  a_clear_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.cell_is_clear) |->
      (out_item.stored_state == ogq_pkg::STATE_CLEAR))
    else $error("clear flag disagrees with stored state");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) || (state_r == ST_FLUSH)) |-> !ram_we)
    else $error("grid written during a query");

  a_scan_center_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && nbr.center) |-> nbr.ok)
    else $error("queried cell found out of bounds");
`endif

endmodule

`default_nettype wire

### rtl/ogq_ram.sv
`default_nettype none

module ogq_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### rtl/ogq_nbr_unit.sv
`default_nettype none

module ogq_nbr_unit (
  input  wire logic [ogq_pkg::COORD_W-1:0] ctr_row,
  input  wire logic [ogq_pkg::COORD_W-1:0] ctr_col,
  input  wire logic [1:0]                  di,
  input  wire logic [1:0]                  dj,
  input  wire logic [ogq_pkg::DIM_W-1:0]   rows,
  input  wire logic [ogq_pkg::DIM_W-1:0]   cols,
  output ogq_pkg::nbr_t                    nbr
);

  logic [ogq_pkg::DIM_W-1:0] row_p;
  logic [ogq_pkg::DIM_W-1:0] col_p;
  logic [ogq_pkg::DIM_W-1:0] row_n;
  logic [ogq_pkg::DIM_W-1:0] col_n;

  // offsets run 0..2; the neighbor sits at (ctr + d - 1)
  always_comb begin
    row_p      = ogq_pkg::DIM_W'(ctr_row) + ogq_pkg::DIM_W'(di);
    col_p      = ogq_pkg::DIM_W'(ctr_col) + ogq_pkg::DIM_W'(dj);
    row_n      = row_p - 1'b1;
    col_n      = col_p - 1'b1;
    nbr.row    = row_n;
    nbr.col    = col_n;
    nbr.ok     = (row_p != '0) && (col_p != '0) && (row_n < rows) && (col_n < cols);
    nbr.center = (di == 2'd1) && (dj == 2'd1);
  end

endmodule

`default_nettype wire
